/* sv/lkr_pkg.sv */
// ----------------------------------------------------------------------------
// lkr_pkg
// Shared types, constants and arithmetic helpers for the keystream rotator.
// ----------------------------------------------------------------------------
package lkr_pkg;

  localparam int unsigned GenW      = 17;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned KeyW      = 7;

  localparam logic [6:0]       LehmerMult = 7'd75;
  localparam logic [GenW-1:0]  LehmerMod  = 17'd65537;
  localparam logic [ByteW-1:0] PrintLo    = 8'd32;
  localparam logic [ByteW-1:0] PrintHi    = 8'd128;
  localparam logic [KeyW-1:0]  PrintSpan  = 7'd96;
  localparam logic [GenW-1:0]  ResetSeed  = 17'd1;

  typedef enum logic [0:0] {
    REG_START_SEED = 1'b0,
    REG_DIRECTION  = 1'b1
  } cfg_reg_e;

  // One classified byte with its key, as carried from front to back.
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             printable;
    logic [GenW-1:0]  key;
  } lkr_item_t;

  // One Lehmer step: g * 75 folded modulo 65537.
  function automatic logic [GenW-1:0] lehmer_advance(input logic [GenW-1:0] g);
    logic [22:0]     prod;
    logic [15:0]     lo;
    logic [6:0]      hi;
    logic [GenW-1:0] res;
    prod = 23'(g * 23'(LehmerMult));
    lo   = prod[15:0];
    hi   = prod[22:16];
    if (lo >= 16'(hi)) begin
      res = 17'(lo) - 17'(hi);
    end else begin
      res = 17'(lo) + LehmerMod - 17'(hi);
    end
    return res;
  endfunction

  // Residue modulo 3 of a 12-bit value: base-4 digits sum, since 4 is 1 mod 3.
  function automatic logic [1:0] mod3_12(input logic [11:0] v);
    logic [4:0] s;
    logic [2:0] t1;
    logic [2:0] t2;
    logic [1:0] res;
    s  = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
    t1 = 3'(s[4:2]) + 3'(s[1:0]);
    t2 = 3'(t1[2]) + 3'(t1[1:0]);
    unique case (t2)
      3'd0, 3'd3: res = 2'd0;
      3'd1, 3'd4: res = 2'd1;
      3'd2:       res = 2'd2;
      default:    res = 2'd0;
    endcase
    return res;
  endfunction

  // Key modulo 96, split as 32 * ((key >> 5) mod 3) + key[4:0].
  function automatic logic [KeyW-1:0] key_mod96(input logic [GenW-1:0] key);
    logic [1:0] m3;
    m3 = mod3_12(key[16:5]);
    return {m3, key[4:0]};
  endfunction

endpackage

/* sv/lkr_front.sv */
// ----------------------------------------------------------------------------
// lkr_front
// Accepts bytes, advances the Lehmer generator and classifies each byte.
// ----------------------------------------------------------------------------
module lkr_front
  import lkr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             seed_we_i,
  input  logic [CfgW-1:0]  seed_i,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output lkr_item_t        push_item_o
);

  logic [GenW-1:0] gen_q;
  logic [GenW-1:0] gen_d;
  logic [GenW-1:0] gen_next;

  assign gen_next = lehmer_advance(gen_q);
  assign push_o   = in_valid_i && !q_full_i;

  always_comb begin
    gen_d = gen_q;
    if (seed_we_i) begin
      gen_d = 17'(seed_i);
    end else if (push_o) begin
      gen_d = gen_next;
    end
  end

  always_comb begin
    push_item_o.in_byte   = in_byte_i;
    push_item_o.printable = (in_byte_i >= PrintLo) && (in_byte_i < PrintHi);
    push_item_o.key       = gen_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= ResetSeed;
    end else begin
      gen_q <= gen_d;
    end
  end

endmodule

/* sv/lkr_fifo.sv */
// ----------------------------------------------------------------------------
// lkr_fifo
// Two-entry queue that decouples the generator front from the rotate back.
// ----------------------------------------------------------------------------
module lkr_fifo
  import lkr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lkr_item_t push_item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      head_valid_o,
  output lkr_item_t head_item_o
);

  lkr_item_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

/* sv/lkr_back.sv */
// ----------------------------------------------------------------------------
// lkr_back
// Rotates printable bytes by the key modulo 96 and holds the output register.
// ----------------------------------------------------------------------------
module lkr_back
  import lkr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             direction_i,
  input  logic             head_valid_i,
  input  lkr_item_t        head_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o
);

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [ByteW-1:0] out_byte_d;
  logic             load_en;
  logic [KeyW-1:0]  k;
  logic [KeyW-1:0]  pos;
  logic [ByteW-1:0] sum;
  logic [ByteW-1:0] wrapped;

  assign load_en = !out_valid_q || !out_stall_i;
  assign pop_o   = head_valid_i && load_en;

  always_comb begin
    k   = key_mod96(head_item_i.key);
    pos = 7'(head_item_i.in_byte - PrintLo);
    if (direction_i) begin
      sum = 8'(pos) + 8'(PrintSpan) - 8'(k);
    end else begin
      sum = 8'(pos) + 8'(k);
    end
    // Both sums stay below twice the span, so one subtract wraps them.
    if (sum >= 8'(PrintSpan)) begin
      wrapped = sum - 8'(PrintSpan);
    end else begin
      wrapped = sum;
    end
    if (head_item_i.printable) begin
      out_byte_d = wrapped + PrintLo;
    end else begin
      out_byte_d = head_item_i.in_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q <= out_byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_en) begin
      out_valid_q <= head_valid_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

/* sv/lehmer_keystream_char_rotator.sv */
// ----------------------------------------------------------------------------
// lehmer_keystream_char_rotator
// Byte stream rotation cipher keyed by a Lehmer generator modulo 65537.
// ----------------------------------------------------------------------------
// Channel  Signals                                  Direction
// in       in_valid_i, in_stall_o, in_byte_i        byte in
// out      out_valid_o, out_stall_i, out_byte_o     byte out
// cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i         register write
//
// One byte per cycle sustained while out_stall_i is low; an accepted beat is
// written into the queue at the accepting edge, then into the output register,
// from which it is presented.
// The generator step is one constant multiply and fold in the front each beat.
// Reset loads the generator with 1 and selects encryption.
// A stall on the output backs up the two-entry queue; in_stall_o rises only
// when the queue is full.
// ----------------------------------------------------------------------------
module lehmer_keystream_char_rotator
  import lkr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i
);

  logic      direction_q;
  logic      seed_we;
  logic      push;
  lkr_item_t push_item;
  logic      pop;
  logic      q_full;
  logic      head_valid;
  lkr_item_t head_item;

  assign seed_we    = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_START_SEED);
  assign in_stall_o = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_DIRECTION)) begin
      direction_q <= cfg_wdata_i[0];
    end
  end

  lkr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we),
    .seed_i      (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  lkr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  lkr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .direction_i  (direction_q),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o)
  );

endmodule
